[src/dsqu_pkg.sv]
// Package for the disjoint-set quick-union unit.
// Holds the table size, field widths, sequencer states and memory request type.
// No dependencies.
package dsqu_pkg;

    // Number of nodes in the parent table
    localparam int NODES = 16;
    // Width of a table index and of a walk step counter
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    // Fixed widths of the word fields
    localparam int FIELD_W = 4;

    // Request operation codes
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_UNION = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_DONE
    } state_t;

    // Access request to the parent table: one read and one write port
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [NODE_W-1:0] wr_data;
    } mem_req_t;

endpackage

[src/dsqu_if.sv]
// Valid/ready channel interfaces for request and result words.
// Depends on dsqu_pkg for the field widths.
interface dsqu_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [dsqu_pkg::FIELD_W-1:0] node_a;
    logic [dsqu_pkg::FIELD_W-1:0] node_b;

    modport source (output valid, output operation, output node_a, output node_b,
                    input ready);
    modport sink   (input valid, input operation, input node_a, input node_b,
                    output ready);
endinterface

interface dsqu_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         result_flag;
    logic [dsqu_pkg::FIELD_W-1:0] root_a;
    logic [dsqu_pkg::FIELD_W-1:0] root_b;

    modport source (output valid, output result_flag, output root_a, output root_b,
                    input ready);
    modport sink   (input valid, input result_flag, input root_a, input root_b,
                    output ready);
endinterface

[src/dsqu_parent_ram.sv]
// Parent table: synchronous RAM with one read and one write port and registered read data.
// Per-entry valid bits make an unwritten entry read back as its own index.
// Depends on dsqu_pkg.
module dsqu_parent_ram (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dsqu_pkg::mem_req_t          req,
    output logic [dsqu_pkg::NODE_W-1:0] rd_data
);

    logic [dsqu_pkg::NODE_W-1:0] mem [dsqu_pkg::NODES];
    logic [dsqu_pkg::NODES-1:0]  valid_reg;
    logic [dsqu_pkg::NODE_W-1:0] rd_data_reg;
    logic [dsqu_pkg::NODE_W-1:0] rd_addr_reg;
    logic                        rd_hit_reg;

    // Storage array and registered read data
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    // Valid bits, cleared at reset so every node starts as its own root
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : rd_addr_reg;

endmodule

[src/disjoint_set_quick_union_unit.sv]
// Disjoint-set quick-union unit: top level with the find sequencer.
// Depends on dsqu_pkg, dsqu_if and dsqu_parent_ram.
//
// Usage:
//   req carries a request word (operation, node_a, node_b); it is taken when
//   valid and ready are both high. rsp carries one result word per request
//   (result_flag, root_a, root_b) under the same handshake.
//   The unit walks parent links of node_a, then of node_b, one table read per
//   cycle through the single read port of the parent RAM. Each walk is capped
//   at NODES reads. The result word is loaded into the output register as the
//   unit returns to idle, where it can take the next request.
//   A union that merges writes the first root's link in the final cycle.
//   Reset leaves every node its own root (valid bits in the RAM, no sweep).
//   When the receiver stalls, the result stays in the output register; the
//   unit still takes and works on the next request, and holds in its final
//   step until the output register is free.
module disjoint_set_quick_union_unit (
    input logic       clk,
    input logic       rst_n,
    dsqu_req_if.sink   req,
    dsqu_rsp_if.source rsp
);

    localparam logic [dsqu_pkg::NODE_W-1:0] LAST_STEP = dsqu_pkg::NODE_W'(dsqu_pkg::NODES - 1);

    dsqu_pkg::state_t            state_reg, state_next;
    logic [dsqu_pkg::NODE_W-1:0] cur_reg, cur_next;
    logic [dsqu_pkg::NODE_W-1:0] step_reg, step_next;
    logic                        op_reg, op_next;
    logic                        skip_reg, skip_next;
    logic [dsqu_pkg::FIELD_W-1:0] b_reg, b_next;
    logic [dsqu_pkg::FIELD_W-1:0] ra_reg, ra_next;
    logic [dsqu_pkg::FIELD_W-1:0] rb_reg, rb_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_flag_reg, out_flag_next;
    logic [dsqu_pkg::FIELD_W-1:0] out_ra_reg, out_ra_next;
    logic [dsqu_pkg::FIELD_W-1:0] out_rb_reg, out_rb_next;

    dsqu_pkg::mem_req_t          mem_req;
    logic [dsqu_pkg::NODE_W-1:0] up;

    logic accept;
    logic out_free;
    logic in_range;
    logic walk_stop;
    logic at_root;
    logic roots_equal;

    dsqu_parent_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (up)
    );

    // Handshake and walk conditions
    assign req.ready   = (state_reg == dsqu_pkg::S_IDLE);
    assign accept      = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign in_range    = (32'(req.node_a) < dsqu_pkg::NODES) &&
                         (32'(req.node_b) < dsqu_pkg::NODES);
    assign at_root     = (up == cur_reg) || (32'(up) >= dsqu_pkg::NODES);
    assign walk_stop   = at_root || (step_reg == LAST_STEP);
    assign roots_equal = (ra_reg == rb_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsqu_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? dsqu_pkg::S_WALK_A : dsqu_pkg::S_DONE;
                end
            end
            dsqu_pkg::S_WALK_A:
            begin
                if (walk_stop)
                begin
                    state_next = dsqu_pkg::S_WALK_B;
                end
            end
            dsqu_pkg::S_WALK_B:
            begin
                if (walk_stop)
                begin
                    state_next = dsqu_pkg::S_DONE;
                end
            end
            dsqu_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = dsqu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dsqu_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory requests and output register loads
    always_comb
    begin
        cur_next       = cur_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        skip_next      = skip_reg;
        b_next         = b_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_flag_next  = out_flag_reg;
        out_ra_next    = out_ra_reg;
        out_rb_next    = out_rb_reg;
        mem_req        = '0;
        case (state_reg)
            dsqu_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = req.operation;
                    skip_next = !in_range;
                    b_next    = req.node_b;
                    ra_next   = req.node_a;
                    rb_next   = req.node_b;
                    cur_next  = dsqu_pkg::NODE_W'(req.node_a);
                    step_next = '0;
                    if (in_range)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = dsqu_pkg::NODE_W'(req.node_a);
                    end
                end
            end
            dsqu_pkg::S_WALK_A:
            begin
                if (walk_stop)
                begin
                    // Root of the first node found; start on the second
                    ra_next         = dsqu_pkg::FIELD_W'(at_root ? cur_reg : up);
                    cur_next        = dsqu_pkg::NODE_W'(b_reg);
                    step_next       = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = dsqu_pkg::NODE_W'(b_reg);
                end
                else
                begin
                    cur_next        = up;
                    step_next       = step_reg + 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = up;
                end
            end
            dsqu_pkg::S_WALK_B:
            begin
                if (walk_stop)
                begin
                    rb_next = dsqu_pkg::FIELD_W'(at_root ? cur_reg : up);
                end
                else
                begin
                    cur_next        = up;
                    step_next       = step_reg + 1'b1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = up;
                end
            end
            dsqu_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ra_next    = ra_reg;
                    out_rb_next    = rb_reg;
                    if (skip_reg)
                    begin
                        out_flag_next = 1'b0;
                    end
                    else if (op_reg == dsqu_pkg::OP_QUERY)
                    begin
                        out_flag_next = roots_equal;
                    end
                    else
                    begin
                        out_flag_next = !roots_equal;
                        // Merge: first root now points at the second root
                        mem_req.wr_en   = !roots_equal;
                        mem_req.wr_addr = dsqu_pkg::NODE_W'(ra_reg);
                        mem_req.wr_data = dsqu_pkg::NODE_W'(rb_reg);
                    end
                end
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsqu_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        step_reg     <= step_next;
        op_reg       <= op_next;
        skip_reg     <= skip_next;
        b_reg        <= b_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        out_flag_reg <= out_flag_next;
        out_ra_reg   <= out_ra_next;
        out_rb_reg   <= out_rb_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_flag = out_flag_reg;
    assign rsp.root_a      = out_ra_reg;
    assign rsp.root_b      = out_rb_reg;

endmodule

[bench/tb_disjoint_set_quick_union_unit.sv]
// Testbench for the disjoint-set quick-union unit: directed, backpressure and random tests.
// Depends on dsqu_pkg, dsqu_if and disjoint_set_quick_union_unit.
`timescale 1ns / 1ps

module tb_disjoint_set_quick_union_unit;

    // Result word as predicted for one request
    typedef struct packed {
        logic                         flag;
        logic [dsqu_pkg::FIELD_W-1:0] root_a;
        logic [dsqu_pkg::FIELD_W-1:0] root_b;
    } root_word_t;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * dsqu_pkg::NODES + 16;
    localparam int SEGMENTS     = 19;
    localparam int SEGMENT_LEN  = 100;

    logic clk = 1'b0;
    logic rst_n;

    dsqu_req_if req_ch ();
    dsqu_rsp_if rsp_ch ();

    disjoint_set_quick_union_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the parent links and the words still owed by the unit
    logic [dsqu_pkg::FIELD_W-1:0] link_table [dsqu_pkg::NODES];
    root_word_t                   pending_roots [$];

    int error_count = 0;
    int quiet_cycles = 0;
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    bit hold_request = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Follow links up to a root, at most NODES steps
    function automatic logic [dsqu_pkg::FIELD_W-1:0] trace_root(
        input logic [dsqu_pkg::FIELD_W-1:0] node);
        logic [dsqu_pkg::FIELD_W-1:0] cur;
        logic [dsqu_pkg::FIELD_W-1:0] up;
        cur = node;
        for (int i = 0; i < dsqu_pkg::NODES; i++)
        begin
            up = link_table[cur];
            if (int'(up) >= dsqu_pkg::NODES || up == cur)
                break;
            cur = up;
        end
        return cur;
    endfunction

    // Update the shadow table for one accepted request and queue its result word
    function automatic void predict_request(input logic op,
                                            input logic [dsqu_pkg::FIELD_W-1:0] a,
                                            input logic [dsqu_pkg::FIELD_W-1:0] b);
        root_word_t w;
        if (int'(a) >= dsqu_pkg::NODES || int'(b) >= dsqu_pkg::NODES)
        begin
            w.flag   = 1'b0;
            w.root_a = a;
            w.root_b = b;
        end
        else
        begin
            w.root_a = trace_root(a);
            w.root_b = trace_root(b);
            if (op == dsqu_pkg::OP_QUERY)
                w.flag = (w.root_a == w.root_b);
            else if (w.root_a == w.root_b)
                w.flag = 1'b0;
            else
            begin
                link_table[w.root_a] = w.root_b;
                w.flag = 1'b1;
            end
        end
        pending_roots.push_back(w);
    endfunction

    // Offer one request word; returns at the falling edge after it is taken
    task automatic send_request(input logic op, input logic [dsqu_pkg::FIELD_W-1:0] a,
                                input logic [dsqu_pkg::FIELD_W-1:0] b);
        int gap;
        gap = send_idle_en ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.node_a    <= a;
        req_ch.node_b    <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_request(op, a, b);
        @(negedge clk);
    endtask

    // Compare one taken result word with the oldest prediction
    task automatic check_result();
        root_word_t w;
        if (pending_roots.size() == 0)
        begin
            error_count++;
            $display("%0t: result word with none expected: flag %0d root_a %0d root_b %0d",
                     $time, rsp_ch.result_flag, rsp_ch.root_a, rsp_ch.root_b);
            return;
        end
        w = pending_roots.pop_front();
        if (rsp_ch.result_flag !== w.flag)
        begin
            error_count++;
            $display("%0t: result_flag mismatch: expected %0d actual %0d",
                     $time, w.flag, rsp_ch.result_flag);
        end
        if (rsp_ch.root_a !== w.root_a)
        begin
            error_count++;
            $display("%0t: root_a mismatch: expected %0d actual %0d",
                     $time, w.root_a, rsp_ch.root_a);
        end
        if (rsp_ch.root_b !== w.root_b)
        begin
            error_count++;
            $display("%0t: root_b mismatch: expected %0d actual %0d",
                     $time, w.root_b, rsp_ch.root_b);
        end
    endtask

    // Result side: random stalls, plus one long hold on request
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = recv_idle_en ? $urandom_range(0, 11) : 0;
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            check_result();
            @(negedge clk);
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_disjoint_set_quick_union_unit failed");
            $finish;
        end
    end

    // Same node, both extremes, a deep chain and repeated unions
    task automatic test_directed();
        send_request(dsqu_pkg::OP_QUERY, 4'd0, 4'd0);
        send_request(dsqu_pkg::OP_UNION, 4'd5, 4'd5);
        send_request(dsqu_pkg::OP_QUERY, 4'd0, 4'd15);
        send_request(dsqu_pkg::OP_UNION, 4'd0, 4'd15);
        send_request(dsqu_pkg::OP_UNION, 4'd15, 4'd0);
        send_request(dsqu_pkg::OP_QUERY, 4'd15, 4'd0);
        // chain 1 -> 2 -> ... -> 8
        for (int n = 1; n < 8; n++)
            send_request(dsqu_pkg::OP_UNION, 4'(n), 4'(n + 1));
        send_request(dsqu_pkg::OP_QUERY, 4'd1, 4'd8);
        send_request(dsqu_pkg::OP_QUERY, 4'd1, 4'd9);
        send_request(dsqu_pkg::OP_UNION, 4'd9, 4'd1);
        send_request(dsqu_pkg::OP_QUERY, 4'd9, 4'd2);
        send_request(dsqu_pkg::OP_UNION, 4'd8, 4'd15);
        send_request(dsqu_pkg::OP_QUERY, 4'd1, 4'd0);
        send_request(dsqu_pkg::OP_QUERY, 4'd14, 4'd1);
        send_request(dsqu_pkg::OP_UNION, 4'd1, 4'd14);
        send_request(dsqu_pkg::OP_QUERY, 4'd1, 4'd14);
    endtask

    // Result side held off while requests keep coming, so the unit stalls its input
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle   = send_idle_en;
        send_idle_en = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
            send_request(dsqu_pkg::OP_QUERY, 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)));
        send_idle_en = saved_idle;
    endtask

    // Mostly queries with a sprinkling of unions; idling varies per segment
    task automatic test_random();
        logic op;
        for (int s = 0; s < SEGMENTS; s++)
        begin
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < SEGMENT_LEN; i++)
            begin
                op = ($urandom_range(0, 7) == 0) ? dsqu_pkg::OP_UNION : dsqu_pkg::OP_QUERY;
                send_request(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            end
        end
    endtask

    // Drain outstanding words, then report
    task automatic finish_run();
        req_ch.valid <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_disjoint_set_quick_union_unit passed");
        else
            $display("tb_disjoint_set_quick_union_unit failed");
        $finish;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = dsqu_pkg::OP_QUERY;
        req_ch.node_a    = '0;
        req_ch.node_b    = '0;
        for (int n = 0; n < dsqu_pkg::NODES; n++)
            link_table[n] = dsqu_pkg::FIELD_W'(n);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random();
        finish_run();
    end

endmodule
